>>> rtl/core/hsd_pkg.sv
package hsd_pkg;

   // word geometry fixed by the port fields
   localparam int WORD_W = 136;
   localparam int LOW_W = 64;
   localparam int MID_W = 64;
   localparam int HIGH_W = WORD_W - LOW_W - MID_W;
   localparam int SYN_OUT_W = 8;
   localparam int POS_OUT_W = 8;
   localparam int COL_IN_W = 8;

   // code geometry
   localparam int CODE_LEN = 136;
   localparam int CHECK_BITS = 8;
   localparam int IDX_W = $clog2(CODE_LEN);
   localparam int CNT_W = $clog2(CODE_LEN + 1);
   localparam logic [IDX_W-1:0] LAST_COL = IDX_W'(CODE_LEN - 1);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SYN,
      ST_MATCH,
      ST_DONE
   } hsd_state_type;

   typedef struct packed {
      logic [WORD_W-1:0]     word;
      logic [CHECK_BITS-1:0] syn_before;
      logic [CHECK_BITS-1:0] syn_after;
      logic                  flipped;
      logic [IDX_W-1:0]      pos;
   } hsd_result_type;

endpackage

>>> rtl/core/hsd_ram.sv
module hsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 136
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/hsd_engine.sv
module hsd_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_operation,
   input  logic [hsd_pkg::COL_IN_W-1:0]   req_column_index,
   input  logic [hsd_pkg::COL_IN_W-1:0]   req_column_value,
   input  logic [hsd_pkg::LOW_W-1:0]      req_word_low,
   input  logic [hsd_pkg::MID_W-1:0]      req_word_mid,
   input  logic [hsd_pkg::HIGH_W-1:0]     req_word_high,
   output logic                           mem_wr_en,
   output logic [hsd_pkg::IDX_W-1:0]      mem_wr_addr,
   output logic [hsd_pkg::CHECK_BITS-1:0] mem_wr_data,
   output logic                           mem_rd_en,
   output logic [hsd_pkg::IDX_W-1:0]      mem_rd_addr,
   input  logic [hsd_pkg::CHECK_BITS-1:0] mem_rd_data,
   output logic                           res_valid,
   input  logic                           res_take,
   output hsd_pkg::hsd_result_type        res
);
   import hsd_pkg::*;

   hsd_state_type         state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  dv_ff, dv_in;
   logic [IDX_W-1:0]      didx_ff, didx_in;
   logic [CHECK_BITS-1:0] syn_ff, syn_in;
   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic [WORD_W-1:0]     word_ff, word_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dv_ff <= dv_in;
      end
      cnt_ff <= cnt_in;
      didx_ff <= didx_in;
      syn_ff <= syn_in;
      hit_ff <= hit_in;
      pos_ff <= pos_in;
      word_ff <= word_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      dv_in = 1'b0;
      didx_in = cnt_ff[IDX_W-1:0];
      syn_in = syn_ff;
      hit_in = hit_ff;
      pos_in = pos_ff;
      word_in = word_ff;
      mem_wr_en = 1'b0;
      mem_rd_en = 1'b0;
      res_valid = 1'b0;
      req_stall = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_operation == OP_DECODE) begin
                  word_in = {req_word_high, req_word_mid, req_word_low};
                  syn_in = '0;
                  hit_in = 1'b0;
                  pos_in = '0;
                  cnt_in = '0;
                  state_in = ST_SYN;
               end else if (req_column_index < COL_IN_W'(CODE_LEN)) begin
                  mem_wr_en = 1'b1;
               end
            end
         end
         ST_SYN, ST_MATCH: begin
            // one column read issued per cycle, data comes back registered in the next cycle
            if (cnt_ff < CNT_W'(CODE_LEN)) begin
               mem_rd_en = 1'b1;
               dv_in = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (dv_ff) begin
               if (state_ff == ST_SYN) begin
                  if (word_ff[didx_ff]) begin
                     syn_in = syn_ff ^ mem_rd_data;
                  end
                  if (didx_ff == LAST_COL) begin
                     cnt_in = '0;
                     state_in = ST_MATCH;
                  end
               end else begin
                  // first matching column wins, flip in place
                  if (!hit_ff && syn_ff != '0 && mem_rd_data == syn_ff) begin
                     hit_in = 1'b1;
                     pos_in = didx_ff;
                     word_in[didx_ff] = ~word_ff[didx_ff];
                  end
                  if (didx_ff == LAST_COL) begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign mem_wr_addr = req_column_index[IDX_W-1:0];
   assign mem_wr_data = req_column_value[CHECK_BITS-1:0];
   assign mem_rd_addr = cnt_ff[IDX_W-1:0];

   // flipping the matched column cancels it out of the syndrome
   assign res.word = word_ff;
   assign res.syn_before = syn_ff;
   assign res.syn_after = hit_ff ? '0 : syn_ff;
   assign res.flipped = hit_ff;
   assign res.pos = pos_ff;

endmodule

>>> rtl/core/programmable_hamming_sec_decoder_top.sv
// single-error-correcting decoder, 136-bit codeword, 8 check rows, loadable H
// input channel (req_): one word per handshake, accepted when req_valid is high
// and req_stall low. req_operation selects a column load or a decode.
// a load writes req_column_value into column req_column_index and gives no
// result; indexes beyond the code are dropped.
// a decode takes the codeword on req_word_low/mid/high and later gives one word
// on the rsp_ channel: corrected word, both syndromes, flip flag and position.
// the column memory has one read port, read once per cycle over a
// syndrome pass and a match pass.
// the block takes one item at a time; req_stall is high while a decode runs.
// the result sits in an output register, so the next item is taken while the
// receiver holds rsp_stall; a second result waits in the engine until then.
// reset clears the control state only; the column table keeps no reset value
// and every column must be loaded before the first decode.
module programmable_hamming_sec_decoder_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [hsd_pkg::COL_IN_W-1:0]  req_column_index,
   input  logic [hsd_pkg::COL_IN_W-1:0]  req_column_value,
   input  logic [hsd_pkg::LOW_W-1:0]     req_word_low,
   input  logic [hsd_pkg::MID_W-1:0]     req_word_mid,
   input  logic [hsd_pkg::HIGH_W-1:0]    req_word_high,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hsd_pkg::LOW_W-1:0]     rsp_fixed_low,
   output logic [hsd_pkg::MID_W-1:0]     rsp_fixed_mid,
   output logic [hsd_pkg::HIGH_W-1:0]    rsp_fixed_high,
   output logic [hsd_pkg::SYN_OUT_W-1:0] rsp_syndrome_before,
   output logic [hsd_pkg::SYN_OUT_W-1:0] rsp_syndrome_after,
   output logic                          rsp_flipped,
   output logic [hsd_pkg::POS_OUT_W-1:0] rsp_flip_position
);
   import hsd_pkg::*;

   logic                  mem_wr_en;
   logic [IDX_W-1:0]      mem_wr_addr;
   logic [CHECK_BITS-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [IDX_W-1:0]      mem_rd_addr;
   logic [CHECK_BITS-1:0] mem_rd_data;
   logic                  res_valid;
   logic                  res_take;
   hsd_result_type        res;

   logic                  rsp_valid_ff, rsp_valid_in;
   hsd_result_type        out_ff;

   hsd_ram #(
      .WIDTH(CHECK_BITS),
      .DEPTH(CODE_LEN)
   ) u_columns (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   hsd_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_column_index (req_column_index),
      .req_column_value (req_column_value),
      .req_word_low     (req_word_low),
      .req_word_mid     (req_word_mid),
      .req_word_high    (req_word_high),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_en        (mem_rd_en),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data),
      .res_valid        (res_valid),
      .res_take         (res_take),
      .res              (res)
   );

   // output register is free when empty or being taken this cycle
   assign res_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid && res_take) begin
         out_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_fixed_low = out_ff.word[LOW_W-1:0];
   assign rsp_fixed_mid = out_ff.word[LOW_W+MID_W-1:LOW_W];
   assign rsp_fixed_high = out_ff.word[WORD_W-1:LOW_W+MID_W];
   assign rsp_syndrome_before = SYN_OUT_W'(out_ff.syn_before);
   assign rsp_syndrome_after = SYN_OUT_W'(out_ff.syn_after);
   assign rsp_flipped = out_ff.flipped;
   assign rsp_flip_position = POS_OUT_W'(out_ff.pos);

endmodule
